// ===== rtl/core/asc_pkg.sv =====
`timescale 1ns / 1ps

package asc_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int CMD_W   = 2;
   localparam int SYM_W   = 8;
   localparam int POS_W   = 8;
   localparam int SIZE_W  = 9;
   localparam int STAT_W  = 2;
   localparam int SHIFT_W = 9;

   // Signed width for shifted positions, one bit above the shift register
   localparam int CALC_W = SHIFT_W + 1;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_ENCODE = 2'd2,
      CMD_DECODE = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_BAD_SHIFT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_RESULT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic search;
      logic apply;
      logic finish;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_clear;
      logic search_done;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== rtl/core/asc_req_if.sv =====
`timescale 1ns / 1ps

interface asc_req_if
   import asc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [SYM_W-1:0] symbol;

   modport source (output valid, output command, output symbol, input ready);
   modport sink   (input valid, input command, input symbol, output ready);
endinterface

// ===== rtl/core/asc_rsp_if.sv =====
`timescale 1ns / 1ps

interface asc_rsp_if
   import asc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [SYM_W-1:0]  out_symbol;
   logic              found;
   logic [POS_W-1:0]  position;
   logic [SIZE_W-1:0] table_size;
   logic [STAT_W-1:0] status;

   modport source (output valid, output out_symbol, output found, output position,
                   output table_size, output status, input ready);
   modport sink   (input valid, input out_symbol, input found, input position,
                   input table_size, input status, output ready);
endinterface

// ===== rtl/core/alphabet_shift_cipher.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake     Payload
// req_chan  in         valid/ready   command, symbol
// rsp_chan  out        valid/ready   out_symbol, found, position, table_size, status
// csr_*     in         write enable  shift_amount (9-bit signed)
//
// One item at a time. Each item passes the search, apply and result states; clear
// skips the table lookup, while other commands search the table, which reads one
// entry per cycle from the single read port.
// Reset (synchronous) empties the table and sets the shift to 1.
// A stalled result sits in the output register; the next item is taken meanwhile.

module alphabet_shift_cipher
   import asc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [SHIFT_W-1:0] csr_write_data,
   asc_req_if.sink            req_chan,
   asc_rsp_if.source          rsp_chan
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   asc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   asc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_command      (req_chan.command),
      .req_symbol       (req_chan.symbol),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_out_symbol   (rsp_chan.out_symbol),
      .rsp_found        (rsp_chan.found),
      .rsp_position     (rsp_chan.position),
      .rsp_table_size   (rsp_chan.table_size),
      .rsp_status       (rsp_chan.status),
      .dp_cmd           (dp_cmd),
      .dp_stat          (dp_stat)
   );

endmodule

// ===== rtl/core/asc_ctrl.sv =====
`timescale 1ns / 1ps

module asc_ctrl
   import asc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // clear needs no lookup
            if (dp_stat.is_clear) begin
               state_in = ST_APPLY;
            end else begin
               dp_cmd.search = 1'b1;
               if (dp_stat.search_done) begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            dp_cmd.apply = 1'b1;
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (dp_stat.out_free) begin
               dp_cmd.finish = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/asc_dpath.sv =====
`timescale 1ns / 1ps

module asc_dpath
   import asc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [SHIFT_W-1:0] csr_write_data,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [SYM_W-1:0]   req_symbol,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [SYM_W-1:0]   rsp_out_symbol,
   output logic               rsp_found,
   output logic [POS_W-1:0]   rsp_position,
   output logic [SIZE_W-1:0]  rsp_table_size,
   output logic [STAT_W-1:0]  rsp_status,
   input  dp_cmd_type         dp_cmd,
   output dp_stat_type        dp_stat
);

   logic [SYM_W-1:0] mem [TABLE_DEPTH];

   logic [SHIFT_W-1:0] shift_ff;
   cmd_type            cmd_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   issue_ff;
   logic               cmp_vld_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   pos_ff;
   logic [SYM_W-1:0]   rd_data_ff;
   status_type         status_ff, status_in;
   logic               subst_ff, subst_in;

   logic                rsp_valid_ff;
   logic [SYM_W-1:0]    rsp_sym_ff;
   logic                rsp_found_ff;
   logic [POS_W-1:0]    rsp_pos_ff;
   logic [SIZE_W-1:0]   rsp_size_ff;
   logic [STAT_W-1:0]   rsp_stat_ff;

   logic               cmp_hit;
   logic               issue_ok;
   logic               search_rd;
   logic               mem_re, mem_we;
   logic [IDX_W-1:0]   rd_addr;
   logic signed [CALC_W-1:0] sh_s, n_s, pos_s, k_raw, k_s;
   logic               shift_bad;

   // Shift register, written any time
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else if (csr_write_enable) begin
         shift_ff <= csr_write_data;
      end
   end

   // Search compare: one table entry per cycle, each read in the cycle before its compare
   assign cmp_hit   = cmp_vld_ff && (rd_data_ff == sym_ff);
   assign issue_ok  = issue_ff < count_ff;
   assign search_rd = dp_cmd.search && issue_ok && !cmp_hit;

   // Shifted position with a single wrap correction
   always_comb begin
      sh_s  = signed'({shift_ff[SHIFT_W-1], shift_ff});
      n_s   = signed'({{(CALC_W-CNT_W){1'b0}}, count_ff});
      pos_s = signed'({{(CALC_W-IDX_W){1'b0}}, pos_ff});
      k_raw = (cmd_ff == CMD_ENCODE) ? pos_s + sh_s : pos_s - sh_s;
      if (k_raw >= n_s) begin
         k_s = k_raw - n_s;
      end else if (k_raw < 0) begin
         k_s = k_raw + n_s;
      end else begin
         k_s = k_raw;
      end
      shift_bad = (sh_s == 0) || (sh_s >= n_s) || (sh_s <= -n_s);
   end

   // Apply the command to count and status
   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      subst_in  = 1'b0;
      mem_we    = 1'b0;
      case (cmd_ff)
         CMD_CLEAR: begin
            count_in = '0;
         end
         CMD_ADD: begin
            if (hit_ff) begin
               status_in = STATUS_DUPLICATE;
            end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
               status_in = STATUS_FULL;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_ENCODE, CMD_DECODE: begin
            if (shift_bad) begin
               status_in = STATUS_BAD_SHIFT;
            end else begin
               subst_in = hit_ff;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign mem_re  = search_rd || (dp_cmd.apply && subst_in);
   assign rd_addr = dp_cmd.apply ? k_s[IDX_W-1:0] : issue_ff[IDX_W-1:0];

   // Symbol table: one write, one registered read
   always_ff @(posedge clock) begin
      if (dp_cmd.apply && mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= sym_ff;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control state: count and search pipeline flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         if (dp_cmd.apply) begin
            count_ff <= count_in;
         end
         cmp_vld_ff <= search_rd;
      end
   end

   // Item registers
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff   <= cmd_type'(req_command);
         sym_ff   <= req_symbol;
         issue_ff <= '0;
         hit_ff   <= 1'b0;
         pos_ff   <= '0;
         subst_ff <= 1'b0;
      end else begin
         if (search_rd) begin
            issue_ff <= issue_ff + 1'b1;
         end
         if (dp_cmd.search && cmp_hit) begin
            hit_ff <= 1'b1;
            pos_ff <= cmp_idx_ff;
         end
         if (dp_cmd.apply) begin
            status_ff <= status_in;
            subst_ff  <= subst_in;
         end
      end
      cmp_idx_ff <= issue_ff[IDX_W-1:0];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.finish) begin
         rsp_sym_ff   <= subst_ff ? rd_data_ff : sym_ff;
         rsp_found_ff <= hit_ff;
         rsp_pos_ff   <= POS_W'(pos_ff);
         rsp_size_ff  <= SIZE_W'(count_ff);
         rsp_stat_ff  <= status_ff;
      end
   end

   assign dp_stat.is_clear    = (cmd_ff == CMD_CLEAR);
   assign dp_stat.search_done = cmp_hit || (!issue_ok && !cmp_vld_ff);
   assign dp_stat.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_symbol = rsp_sym_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_table_size = rsp_size_ff;
   assign rsp_status     = rsp_stat_ff;

endmodule

// ===== rtl/core/asc_checker.sv =====
`timescale 1ns / 1ps

module asc_checker
   import asc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [SYM_W-1:0]  rsp_out_symbol,
   input logic              rsp_found,
   input logic [POS_W-1:0]  rsp_position,
   input logic [SIZE_W-1:0] rsp_table_size,
   input logic [STAT_W-1:0] rsp_status
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_symbol)
         && $stable(rsp_status) && $stable(rsp_table_size))
      else $error("stalled result changed");

   // Duplicate add always reports the hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_DUPLICATE) |-> rsp_found)
      else $error("duplicate without found");

   // Miss reports position zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_position == '0))
      else $error("nonzero position on miss");

   // Full only with a full table and no hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL)
         |-> (rsp_table_size == SIZE_W'(TABLE_DEPTH)) && !rsp_found)
      else $error("full status with room left");

   // Size never passes the depth, and a hit lies inside the table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_table_size <= SIZE_W'(TABLE_DEPTH))
         && (!rsp_found || (SIZE_W'(rsp_position) < rsp_table_size)))
      else $error("size or position out of range");

endmodule

bind alphabet_shift_cipher asc_checker u_asc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_symbol (rsp_chan.out_symbol),
   .rsp_found      (rsp_chan.found),
   .rsp_position   (rsp_chan.position),
   .rsp_table_size (rsp_chan.table_size),
   .rsp_status     (rsp_chan.status)
);
